>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the sequencer RTL
// Clocked property checks with a synchronous reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define SDCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sequencer assertion failed");

// Check that cond at one edge is followed by result at the next edge.
`define SDCS_ASSERT_NEXT(lbl, clk, rst, cond, result) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
      else $error("sequencer assertion failed");

`endif

>>> rtl/sdcs_pkg.sv
// ----------------------------------------------------------------------------
// Sensor duty-cycle sequencer package
// Register indexes, reset values and the item types shared by the modules and interfaces.
// ----------------------------------------------------------------------------
package sdcs_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int TIME_W      = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [TIME_W-1:0]      time_ms_type;

   // register indexes of the configuration port
   localparam csr_index_type CSR_AWAKE_TIME = 2'd0;
   localparam csr_index_type CSR_MIN_SLEEP  = 2'd1;
   localparam csr_index_type CSR_CYCLING    = 2'd2;

   // register values after reset
   localparam time_ms_type DEF_AWAKE_MS     = 32'd30000;
   localparam time_ms_type DEF_MIN_SLEEP_MS = 32'd60000;
   localparam logic        DEF_CYCLING      = 1'b1;

   // operation codes of an input item
   localparam logic OP_UPDATE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      time_ms_type awake_time_ms;
      time_ms_type min_sleep_time_ms;
      logic        cycling_enabled;
   } cfg_type;

   typedef struct packed {
      logic        op;
      time_ms_type now_ms;
      logic        sensing_on;
      logic        wake_done;
      logic        wake_request;
   } req_item_type;

   typedef struct packed {
      logic sensors_asleep;
      logic wakeup_active;
      logic service_wakeup;
      logic sample_keypad;
      logic sample_everything;
      logic start_wakeup;
      logic send_report;
      logic put_to_sleep;
   } rsp_item_type;

endpackage

>>> rtl/sdcs_if.sv
// ----------------------------------------------------------------------------
// Sequencer stream interfaces
// Valid/ready channels for input items and action results.
// ----------------------------------------------------------------------------
interface sdcs_req_if;
   import sdcs_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface sdcs_rsp_if;
   import sdcs_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

>>> rtl/sdcs_csr.sv
// ----------------------------------------------------------------------------
// Sequencer configuration registers
// Write-only register file for awake time, minimum sleep time and cycling.
// ----------------------------------------------------------------------------
module sdcs_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  sdcs_pkg::csr_index_type csr_index,
   input  sdcs_pkg::csr_data_type  csr_wdata,
   output sdcs_pkg::cfg_type     cfg
);
   import sdcs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AWAKE_TIME: cfg_in.awake_time_ms     = csr_wdata[TIME_W-1:0];
            CSR_MIN_SLEEP:  cfg_in.min_sleep_time_ms = csr_wdata[TIME_W-1:0];
            CSR_CYCLING:    cfg_in.cycling_enabled   = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.awake_time_ms     <= DEF_AWAKE_MS;
         cfg_ff.min_sleep_time_ms <= DEF_MIN_SLEEP_MS;
         cfg_ff.cycling_enabled   <= DEF_CYCLING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/sdcs_phase_fsm.sv
// ----------------------------------------------------------------------------
// Sequencer phase machine
// Holds phase, phase start time and wake flag; decodes one item into actions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdcs_phase_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  sdcs_pkg::cfg_type      cfg,
   input  logic                   advance,
   input  sdcs_pkg::req_item_type item,
   output sdcs_pkg::rsp_item_type actions
);
   import sdcs_pkg::*;

   typedef enum logic [1:0] {
      PH_WAKING   = 2'd0,
      PH_AWAKE    = 2'd1,
      PH_SLEEPING = 2'd2
   } phase_type;

   phase_type    phase_ff;
   phase_type    phase_in;
   time_ms_type  start_ff;
   time_ms_type  start_in;
   logic         wake_started_ff;
   logic         wake_started_in;
   time_ms_type  duration;
   time_ms_type  since_start;
   logic         elapsed;
   rsp_item_type act;

   // wrap-safe phase age against the limit of the current phase
   assign duration    = (phase_ff == PH_SLEEPING) ? cfg.min_sleep_time_ms
                                                  : cfg.awake_time_ms;
   assign since_start = item.now_ms - start_ff;
   assign elapsed     = (since_start >= duration);

   // next phase and action flags for the item at the head
   always_comb begin
      phase_in        = phase_ff;
      start_in        = start_ff;
      wake_started_in = wake_started_ff;
      act             = '0;
      if (item.op == OP_RESTART) begin
         phase_in        = PH_WAKING;
         start_in        = item.now_ms;
         wake_started_in = 1'b0;
      end else if (!cfg.cycling_enabled) begin
         phase_in              = PH_AWAKE;
         act.sample_everything = item.sensing_on;
         act.sample_keypad     = !item.sensing_on;
      end else begin
         unique case (phase_ff)
            PH_AWAKE: begin
               act.send_report       = 1'b1;
               act.sample_everything = item.sensing_on;
               act.sample_keypad     = !item.sensing_on;
               if (elapsed) begin
                  phase_in              = PH_SLEEPING;
                  start_in              = item.now_ms;
                  act.sample_everything = 1'b0;
                  act.sample_keypad     = 1'b1;
                  act.put_to_sleep      = 1'b1;
                  act.sensors_asleep    = 1'b1;
               end
            end
            PH_SLEEPING: begin
               act.sensors_asleep = 1'b1;
               act.sample_keypad  = 1'b1;
               if (elapsed && item.wake_request) begin
                  phase_in           = PH_WAKING;
                  start_in           = item.now_ms;
                  wake_started_in    = 1'b1;
                  act.sensors_asleep = 1'b0;
                  act.sample_keypad  = 1'b0;
                  act.wakeup_active  = 1'b1;
                  act.service_wakeup = 1'b1;
                  act.start_wakeup   = 1'b1;
               end
            end
            default: begin
               act.wakeup_active  = 1'b1;
               act.service_wakeup = 1'b1;
               act.sample_keypad  = 1'b1;
               if (!wake_started_ff) begin
                  act.start_wakeup = 1'b1;
                  wake_started_in  = 1'b1;
               end
               if (item.wake_done) begin
                  phase_in           = PH_AWAKE;
                  start_in           = item.now_ms;
                  act.wakeup_active  = 1'b0;
                  act.service_wakeup = 1'b0;
                  act.sample_keypad  = 1'b0;
               end
            end
         endcase
      end
   end

   // advance the phase state once per transfer into the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAKING;
         start_ff        <= '0;
         wake_started_ff <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         start_ff        <= start_in;
         wake_started_ff <= wake_started_in;
      end
   end

   assign actions = act;

   `SDCS_ASSERT_NEXT(a_restart_wakes, clock, reset,
      advance && (item.op == OP_RESTART),
      (phase_ff == PH_WAKING) && !wake_started_ff && (start_ff == $past(item.now_ms)))
   `SDCS_ASSERT_NEXT(a_start_marks_wake, clock, reset,
      advance && act.start_wakeup, wake_started_ff)
   `SDCS_ASSERT_NEXT(a_sleep_enters_sleeping, clock, reset,
      advance && act.put_to_sleep, phase_ff == PH_SLEEPING)

endmodule

>>> rtl/sensor_duty_cycle_sequencer_core.sv
// ----------------------------------------------------------------------------
// Sensor duty-cycle sequencer core
// Input stage, phase machine and result register for the sensor power cycle.
// ----------------------------------------------------------------------------
// Each transfer on req_chan carries an op code, a timestamp and three
// status flags; each yields exactly one transfer on rsp_chan with eight
// action flags, in order. Both channels use valid/ready. The csr_ port
// writes awake time, minimum sleep time and the cycling enable, one
// register per cycle, and must be used only while no item is in flight,
// which the block itself does not enforce. An item waits in the input
// register, where the phase machine decodes it with one 32-bit subtract
// and compare, and then moves into the result register, which drives
// rsp_chan.valid. One item per cycle is sustained while rsp_chan.ready
// stays high, since the phase state updates in the same cycle that the
// item moves on.
// Reset empties both registers, restores the register defaults and puts
// the phase machine in waking with start time zero. While the receiver
// holds rsp_chan.ready low, the result holds and one more item waits in
// the input register; req_chan.ready then drops until the result goes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_duty_cycle_sequencer_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  sdcs_pkg::csr_index_type csr_index,
   input  sdcs_pkg::csr_data_type  csr_wdata,
   sdcs_req_if.sink                req_chan,
   sdcs_rsp_if.source              rsp_chan
);
   import sdcs_pkg::*;

   cfg_type      cfg;
   rsp_item_type actions;
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   logic         out_free;
   logic         advance;
   logic         in_take;

   sdcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdcs_phase_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (in_item_ff),
      .actions (actions)
   );

   // move the held item on when the result register is free or draining
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_take        = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture payloads on transfer
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_item_ff <= req_chan.item;
      end
      if (advance) begin
         out_item_ff <= actions;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.item  = out_item_ff;

   `SDCS_ASSERT_NEXT(a_take_fills_input, clock, reset,
      in_take, in_valid_ff && (in_item_ff == $past(req_chan.item)))
   `SDCS_ASSERT_NEXT(a_advance_fills_result, clock, reset,
      advance, out_valid_ff && (out_item_ff == $past(actions)))

endmodule
